FILE: rtl/stt_pkg.sv
package stt_pkg;

  // Default geometry of the table.
  localparam int DEFAULT_SLOTS       = 8;
  localparam int DEFAULT_DIGEST_BITS = 64;

  // Fixed field widths.
  localparam int TIME_BITS      = 48;
  localparam int TOKEN_BITS     = 64;
  localparam int MODE_BITS      = 3;
  localparam int STATUS_BITS    = 3;
  localparam int SLOT_OUT_BITS  = 3;
  localparam int COUNT_OUT_BITS = 4;
  localparam int IDLE_CFG_BITS  = 11;
  localparam int LIFE_CFG_BITS  = 14;

  // Stream and configuration port widths.
  localparam int S_TDATA_BITS    = 112;
  localparam int S_TUSER_BITS    = 4;
  localparam int M_TDATA_BITS    = 16;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 14;

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDLE_LIMIT     = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LIFETIME_LIMIT = 1'b1;
  localparam logic [IDLE_CFG_BITS-1:0]  IDLE_LIMIT_RESET   = 11'd15;
  localparam logic [LIFE_CFG_BITS-1:0]  LIFE_LIMIT_RESET   = 14'd24;

  // Microseconds per minute and per hour.
  localparam logic [TIME_BITS-1:0] US_PER_MIN  = 48'd60_000_000;
  localparam logic [TIME_BITS-1:0] US_PER_HOUR = 48'd3_600_000_000;

  // Request modes.
  localparam logic [MODE_BITS-1:0] MODE_CREATE      = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_VALIDATE    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_DESTROY     = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_DESTROY_ALL = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_CLEANUP     = 3'd4;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] STATUS_OK           = 3'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND    = 3'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_LIFE_EXPIRED = 3'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_IDLE_EXPIRED = 3'd3;
  localparam logic [STATUS_BITS-1:0] STATUS_MALFORMED    = 3'd4;

  // One request as taken from the input stream.
  typedef struct packed {
    logic [MODE_BITS-1:0]  mode;
    logic [TOKEN_BITS-1:0] token_digest;
    logic                  token_well_formed;
    logic [TIME_BITS-1:0]  now_us;
  } stt_item_t;

  // One result item.
  typedef struct packed {
    logic [STATUS_BITS-1:0]    status;
    logic [SLOT_OUT_BITS-1:0]  slot_index;
    logic                      evicted_live;
    logic [COUNT_OUT_BITS-1:0] expired_count;
  } stt_result_t;

  // Timeout limits in microseconds.
  typedef struct packed {
    logic [TIME_BITS-1:0] life_us;
    logic [TIME_BITS-1:0] idle_us;
  } stt_limits_t;

  // Outcome of evaluating one table entry.
  typedef struct packed {
    logic                 match;
    logic                 life_over;
    logic                 idle_over;
    logic                 older;
    logic [TIME_BITS-1:0] age;
  } stt_verdict_t;

endpackage

FILE: rtl/stt_limits.sv
module stt_limits
  import stt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output stt_limits_t               limits
);

  logic [IDLE_CFG_BITS-1:0] idle_minutes;
  logic [LIFE_CFG_BITS-1:0] life_hours;

  // Registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_minutes <= IDLE_LIMIT_RESET;
      life_hours   <= LIFE_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDLE_LIMIT:     idle_minutes <= cfg_data[IDLE_CFG_BITS-1:0];
        CFG_LIFETIME_LIMIT: life_hours   <= cfg_data[LIFE_CFG_BITS-1:0];
      endcase
    end
  end

  // Limits scaled to microseconds; each is a narrow value times a constant.
  always_ff @(posedge clk) begin
    limits.idle_us <= TIME_BITS'(idle_minutes) * US_PER_MIN;
    limits.life_us <= TIME_BITS'(life_hours) * US_PER_HOUR;
  end

endmodule

FILE: rtl/stt_age_unit.sv
module stt_age_unit
  import stt_pkg::*;
#(
  parameter int DIG_BITS = DEFAULT_DIGEST_BITS
) (
  input  logic [TIME_BITS-1:0] now,
  input  logic [TIME_BITS-1:0] created,
  input  logic [TIME_BITS-1:0] last_seen,
  input  logic [TIME_BITS-1:0] best_age,
  input  stt_limits_t          limits,
  input  logic [DIG_BITS-1:0]  key,
  input  logic [DIG_BITS-1:0]  entry_digest,
  output stt_verdict_t         verdict
);

  logic [TIME_BITS-1:0] life_age;
  logic [TIME_BITS-1:0] idle_age;

  // Ages wrap modulo the width of the time counter.
  assign life_age = now - created;
  assign idle_age = now - last_seen;

  // Digest match, both timeout tests and the oldest-entry compare.
  assign verdict.match     = (key == entry_digest);
  assign verdict.life_over = (life_age > limits.life_us);
  assign verdict.idle_over = (idle_age > limits.idle_us);
  assign verdict.older     = (idle_age > best_age);
  assign verdict.age       = idle_age;

endmodule

FILE: rtl/stt_ctrl.sv
module stt_ctrl
  import stt_pkg::*;
#(
  parameter int SLOTS    = DEFAULT_SLOTS,
  parameter int DIG_BITS = DEFAULT_DIGEST_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  stt_item_t   item,
  input  stt_limits_t limits,
  input  logic        out_free,
  output logic        res_valid,
  output stt_result_t res
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  typedef struct packed {
    logic [DIG_BITS-1:0]  digest;
    logic [TIME_BITS-1:0] created;
    logic [TIME_BITS-1:0] last_seen;
  } entry_t;

  logic [1:0]           state;
  logic [MODE_BITS-1:0] mode;
  logic [DIG_BITS-1:0]  key;
  logic [TIME_BITS-1:0] now;
  logic [SLOTS-1:0]     valid;
  logic [SLOT_W-1:0]    scan_ptr;
  logic                 issuing;
  logic                 eval_valid;
  logic [SLOT_W-1:0]    eval_slot;
  logic [SLOT_W-1:0]    pick;
  logic                 evict_live;
  logic [TIME_BITS-1:0] best_age;
  logic                 found;
  logic                 match_life;
  logic                 match_idle;
  logic [TIME_BITS-1:0] match_created;
  logic [CNT_W-1:0]     cnt;
  logic [STATUS_BITS-1:0] res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic                 res_evl;

  entry_t               mem [SLOTS];
  entry_t               rd_entry;
  entry_t               wr_entry;
  logic                 wr_en;

  logic                 free_any;
  logic [SLOT_W-1:0]    free_slot;
  stt_verdict_t         verdict;

  // Lowest free slot from the valid bits.
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  // Shared entry evaluator, fed one slot per cycle during a scan.
  stt_age_unit #(
    .DIG_BITS (DIG_BITS)
  ) u_age (
    .now          (now),
    .created      (rd_entry.created),
    .last_seen    (rd_entry.last_seen),
    .best_age     (best_age),
    .limits       (limits),
    .key          (key),
    .entry_digest (rd_entry.digest),
    .verdict      (verdict)
  );

  // Entry write-back: a new session, or a refreshed last-seen time.
  always_comb begin
    wr_en = (state == ST_FINISH) &&
            ((mode == MODE_CREATE) ||
             ((mode == MODE_VALIDATE) && found && !match_life && !match_idle));
    wr_entry.digest    = key;
    wr_entry.created   = (mode == MODE_CREATE) ? now : match_created;
    wr_entry.last_seen = now;
  end

  // Entry memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pick] <= wr_entry;
    end
    rd_entry <= mem[scan_ptr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= '0;
      issuing    <= 1'b0;
      eval_valid <= 1'b0;
    end else begin
      eval_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            mode       <= item.mode;
            key        <= item.token_digest[DIG_BITS-1:0];
            now        <= item.now_us;
            res_status <= STATUS_OK;
            res_slot   <= '0;
            res_evl    <= 1'b0;
            cnt        <= '0;
            found      <= 1'b0;
            evict_live <= 1'b0;
            best_age   <= '0;
            scan_ptr   <= '0;
            issuing    <= 1'b0;
            if ((item.mode <= MODE_DESTROY) && !item.token_well_formed) begin
              res_status <= STATUS_MALFORMED;
              state      <= ST_DONE;
            end else begin
              unique case (item.mode)
                MODE_CREATE: begin
                  if (free_any) begin
                    pick  <= free_slot;
                    state <= ST_FINISH;
                  end else begin
                    issuing <= 1'b1;
                    state   <= ST_SCAN;
                  end
                end
                MODE_VALIDATE, MODE_DESTROY, MODE_CLEANUP: begin
                  issuing <= 1'b1;
                  state   <= ST_SCAN;
                end
                MODE_DESTROY_ALL: begin
                  valid <= '0;
                  state <= ST_DONE;
                end
                default: begin
                  res_status <= STATUS_NOT_FOUND;
                  state      <= ST_DONE;
                end
              endcase
            end
          end
        end

        ST_SCAN: begin
          // Issue one read per cycle; its data is evaluated in the next cycle.
          if (issuing) begin
            if (scan_ptr == LAST_SLOT) begin
              issuing <= 1'b0;
            end else begin
              scan_ptr <= scan_ptr + 1'b1;
            end
          end
          eval_valid <= issuing;
          eval_slot  <= scan_ptr;

          if (eval_valid) begin
            if (mode == MODE_CREATE) begin
              // Table is full: keep the entry idle the longest.
              if ((eval_slot == '0) || verdict.older) begin
                best_age   <= verdict.age;
                pick       <= eval_slot;
                evict_live <= !(verdict.life_over || verdict.idle_over);
              end
            end else if (mode == MODE_CLEANUP) begin
              if (valid[eval_slot] && (verdict.life_over || verdict.idle_over)) begin
                valid[eval_slot] <= 1'b0;
                cnt              <= cnt + 1'b1;
              end
            end else if (valid[eval_slot] && verdict.match) begin
              found         <= 1'b1;
              pick          <= eval_slot;
              match_life    <= verdict.life_over;
              match_idle    <= verdict.idle_over;
              match_created <= rd_entry.created;
              state         <= ST_FINISH;
            end
            if (eval_slot == LAST_SLOT) begin
              state <= ST_FINISH;
            end
          end
        end

        ST_FINISH: begin
          issuing <= 1'b0;
          state   <= ST_DONE;
          unique case (mode)
            MODE_CREATE: begin
              valid[pick] <= 1'b1;
              res_slot    <= pick;
              res_evl     <= evict_live;
            end
            MODE_VALIDATE: begin
              if (found) begin
                res_slot <= pick;
                if (match_life) begin
                  res_status  <= STATUS_LIFE_EXPIRED;
                  valid[pick] <= 1'b0;
                end else if (match_idle) begin
                  res_status  <= STATUS_IDLE_EXPIRED;
                  valid[pick] <= 1'b0;
                end
              end else begin
                res_status <= STATUS_NOT_FOUND;
              end
            end
            MODE_DESTROY: begin
              if (found) begin
                res_slot    <= pick;
                valid[pick] <= 1'b0;
              end else begin
                res_status <= STATUS_NOT_FOUND;
              end
            end
            default: begin
              res_status <= STATUS_OK;
            end
          endcase
        end

        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Handshake toward the top level.
  assign item_ready = (state == ST_IDLE);
  assign res_valid  = (state == ST_DONE) && out_free;

  assign res.status        = res_status;
  assign res.slot_index    = SLOT_OUT_BITS'(res_slot);
  assign res.evicted_live  = res_evl;
  assign res.expired_count = COUNT_OUT_BITS'(cnt);

endmodule

FILE: rtl/session_table_with_timeouts.sv
// Channel   Direction  Handshake                Payload
// s_*       in         s_tvalid / s_tready      s_tdata, s_tuser: one request
// m_*       out        m_tvalid / m_tready      m_tdata: one result per request
// cfg_*     in         cfg_valid / cfg_ready    cfg_index, cfg_data: limit write
//
// A full table scan reads the entry memory one slot per cycle, so a create on
// a full table, validate, destroy and cleanup, which scan the table, take
// longer than other requests; validate and destroy stop at the first match.
// Each result waits in the done state until the output register is free.
// Reset clears the valid bits at once and restores the limit registers.
// A result held in the output register does not stall the next request; only
// its completion waits for the register to drain.
module session_table_with_timeouts
  import stt_pkg::*;
#(
  parameter int SESSION_SLOTS = DEFAULT_SLOTS,
  parameter int DIGEST_BITS   = DEFAULT_DIGEST_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [S_TDATA_BITS-1:0]   s_tdata,   // token_digest[63:0], now_us[111:64]
  input  logic [S_TUSER_BITS-1:0]   s_tuser,   // mode[2:0], token_well_formed[3]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [M_TDATA_BITS-1:0]   m_tdata,   // status[2:0], slot_index[5:3],
                                               // evicted_live[6], expired_count[10:7]
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  stt_item_t   item;
  stt_limits_t limits;
  stt_result_t res;
  logic        res_valid;
  logic        out_free;

  // Unpack the request fields.
  assign item.token_digest      = s_tdata[TOKEN_BITS-1:0];
  assign item.now_us            = s_tdata[TOKEN_BITS +: TIME_BITS];
  assign item.mode              = s_tuser[MODE_BITS-1:0];
  assign item.token_well_formed = s_tuser[MODE_BITS];

  stt_limits u_limits (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  stt_ctrl #(
    .SLOTS    (SESSION_SLOTS),
    .DIG_BITS (DIGEST_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s_tvalid),
    .item_ready (s_tready),
    .item       (item),
    .limits     (limits),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Output register; free when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= M_TDATA_BITS'({res.expired_count, res.evicted_live,
                                res.slot_index, res.status});
    end
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  import stt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS          = DEFAULT_SLOTS;
  localparam int POOL_SIZE      = 12;
  localparam int PHASE_ITEMS    = 112;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [S_TDATA_BITS-1:0]   s_tdata   = '0;
  logic [S_TUSER_BITS-1:0]   s_tuser   = '0;
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [M_TDATA_BITS-1:0]   m_tdata;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_IDLE_LIMIT;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  // Shadow copy of the session table and its limits.
  logic                     tbl_valid     [SLOTS];
  logic [TOKEN_BITS-1:0]    tbl_digest    [SLOTS];
  logic [TIME_BITS-1:0]     tbl_created   [SLOTS];
  logic [TIME_BITS-1:0]     tbl_last_seen [SLOTS];
  logic [IDLE_CFG_BITS-1:0] idle_minutes = IDLE_LIMIT_RESET;
  logic [LIFE_CFG_BITS-1:0] life_hours   = LIFE_LIMIT_RESET;

  stt_item_t   pending_requests [$];
  stt_result_t expected_results [$];
  stt_item_t   drive_req;
  stt_item_t   seen_req;
  stt_result_t seen_result;
  stt_result_t want_result;

  logic [TOKEN_BITS-1:0] digest_pool [POOL_SIZE];
  logic [TIME_BITS-1:0]  clock_us;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_requests  = 0;
  int          holds_served   = 0;
  int          hold_left      = 0;
  int          fail_count     = 0;
  int          quiet_cycles   = 0;

  session_table_with_timeouts u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // token_digest[63:0], now_us[111:64]
    .s_tuser   (s_tuser),   // mode[2:0], token_well_formed[3]
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // status[2:0], slot_index[5:3], evicted_live[6],
                            // expired_count[10:7]
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] idle_limit_us();
    return 64'(idle_minutes) * 64'(US_PER_MIN);
  endfunction

  function automatic logic [63:0] life_limit_us();
    return 64'(life_hours) * 64'(US_PER_HOUR);
  endfunction

  // Lifetime is tested before idle time; differences wrap at 48 bits.
  function automatic logic [STATUS_BITS-1:0] expiry_status(input int s,
                                                           input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] since_created;
    logic [TIME_BITS-1:0] since_seen;
    since_created = now - tbl_created[s];
    since_seen    = now - tbl_last_seen[s];
    if (64'(since_created) > life_limit_us()) return STATUS_LIFE_EXPIRED;
    if (64'(since_seen) > idle_limit_us()) return STATUS_IDLE_EXPIRED;
    return STATUS_OK;
  endfunction

  function automatic int find_session(input logic [TOKEN_BITS-1:0] digest);
    int s;
    for (s = 0; s < SLOTS; s++)
      if (tbl_valid[s] && tbl_digest[s] == digest) return s;
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the result it yields.
  function automatic stt_result_t apply_request(input stt_item_t req);
    stt_result_t          res;
    int                   s;
    int                   pick;
    int                   hit;
    logic [TIME_BITS-1:0] age;
    logic [TIME_BITS-1:0] oldest;
    res = '0;
    hit = find_session(req.token_digest);
    if (req.mode <= MODE_DESTROY && !req.token_well_formed) begin
      res.status = STATUS_MALFORMED;
    end else begin
      case (req.mode)
        MODE_CREATE: begin
          pick = -1;
          for (s = SLOTS - 1; s >= 0; s--)
            if (!tbl_valid[s]) pick = s;
          // Full table: evict the entry unused the longest, lowest index on ties.
          if (pick < 0) begin
            pick   = 0;
            oldest = req.now_us - tbl_last_seen[0];
            for (s = 1; s < SLOTS; s++) begin
              age = req.now_us - tbl_last_seen[s];
              if (age > oldest) begin
                oldest = age;
                pick   = s;
              end
            end
            res.evicted_live = (expiry_status(pick, req.now_us) == STATUS_OK);
          end
          tbl_valid[pick]     = 1'b1;
          tbl_digest[pick]    = req.token_digest;
          tbl_created[pick]   = req.now_us;
          tbl_last_seen[pick] = req.now_us;
          res.slot_index      = 3'(pick);
        end
        MODE_VALIDATE: begin
          if (hit < 0) begin
            res.status = STATUS_NOT_FOUND;
          end else begin
            res.slot_index = 3'(hit);
            res.status     = expiry_status(hit, req.now_us);
            if (res.status != STATUS_OK) tbl_valid[hit] = 1'b0;
            else tbl_last_seen[hit] = req.now_us;
          end
        end
        MODE_DESTROY: begin
          if (hit < 0) begin
            res.status = STATUS_NOT_FOUND;
          end else begin
            res.slot_index     = 3'(hit);
            tbl_valid[hit]     = 1'b0;
            tbl_digest[hit]    = '0;
            tbl_created[hit]   = '0;
            tbl_last_seen[hit] = '0;
          end
        end
        MODE_DESTROY_ALL: begin
          for (s = 0; s < SLOTS; s++) begin
            tbl_valid[s]     = 1'b0;
            tbl_digest[s]    = '0;
            tbl_created[s]   = '0;
            tbl_last_seen[s] = '0;
          end
        end
        MODE_CLEANUP: begin
          for (s = 0; s < SLOTS; s++) begin
            if (tbl_valid[s] && expiry_status(s, req.now_us) != STATUS_OK) begin
              tbl_valid[s]      = 1'b0;
              res.expired_count = res.expired_count + 1'b1;
            end
          end
        end
        default: begin
          res.status = STATUS_NOT_FOUND;
        end
      endcase
    end
    return res;
  endfunction

  // Builds one random request. Time mostly moves forward in small steps or in
  // steps sized to the current limits, sometimes lands on or just past a live
  // entry's deadline, or jumps anywhere, including just below the wrap point.
  function automatic stt_item_t next_request();
    stt_item_t            req;
    int unsigned          r;
    int                   s;
    bit                   aimed;
    logic [63:0]          idle_us;
    logic [63:0]          life_us;
    logic [63:0]          step;
    logic [TIME_BITS-1:0] deadline;
    idle_us = idle_limit_us();
    life_us = life_limit_us();
    aimed   = 1'b0;
    step    = '0;
    req.token_digest = ($urandom_range(99) < 90) ?
                       digest_pool[$urandom_range(POOL_SIZE - 1)] : rand64();
    r = $urandom_range(99);
    if (r < 10) begin
      step = '0;
    end else if (r < 40) begin
      step = rand64() % 64'd1001;
    end else if (r < 60) begin
      step = rand64() % (idle_us / 2 + 1);
    end else if (r < 75) begin
      step = idle_us / 2 + rand64() % (idle_us + 1);
    end else if (r < 85) begin
      s = $urandom_range(SLOTS - 1);
      if (tbl_valid[s]) begin
        aimed    = 1'b1;
        deadline = $urandom_range(1) ? tbl_last_seen[s] + idle_us[TIME_BITS-1:0] :
                                       tbl_created[s] + life_us[TIME_BITS-1:0];
        clock_us = deadline + TIME_BITS'($urandom_range(1));
        req.token_digest = tbl_digest[s];
      end
    end else if (r < 93) begin
      step = life_us - idle_us / 2 + rand64() % (idle_us + 1);
    end else if (r < 97) begin
      clock_us = TIME_BITS'(rand64());
    end else begin
      clock_us = {TIME_BITS{1'b1}} - TIME_BITS'($urandom_range(3000));
    end
    clock_us = clock_us + step[TIME_BITS-1:0];

    r = $urandom_range(99);
    if (aimed) begin
      req.mode = (r < 60) ? MODE_VALIDATE : (r < 80) ? MODE_CLEANUP : MODE_CREATE;
    end else if (r < 30) begin
      req.mode = MODE_CREATE;
    end else if (r < 62) begin
      req.mode = MODE_VALIDATE;
    end else if (r < 74) begin
      req.mode = MODE_DESTROY;
    end else if (r < 77) begin
      req.mode = MODE_DESTROY_ALL;
    end else if (r < 93) begin
      req.mode = MODE_CLEANUP;
    end else if (r < 96) begin
      req.mode = MODE_MAX_UNUSED();
    end else begin
      req.mode = MODE_VALIDATE;
    end
    req.token_well_formed = ($urandom_range(99) < 94);
    req.now_us            = clock_us;
    return req;
  endfunction

  // Modes above cleanup are not assigned to any operation.
  function automatic logic [MODE_BITS-1:0] MODE_MAX_UNUSED();
    return MODE_BITS'($urandom_range(7, 32'(MODE_CLEANUP) + 1));
  endfunction

  // Request driver: holds each transaction until it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_req = pending_requests.pop_front();
        s_tdata  <= {drive_req.now_us, drive_req.token_digest};
        s_tuser  <= {drive_req.token_well_formed, drive_req.mode};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus an occasional long hold-off.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checks each result transaction, then predicts for each accepted request.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        seen_result.status        = m_tdata[2:0];
        seen_result.slot_index    = m_tdata[5:3];
        seen_result.evicted_live  = m_tdata[6];
        seen_result.expired_count = m_tdata[10:7];
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("[%0t] unexpected result: status %0d slot %0d evicted %0d count %0d",
                     $realtime, seen_result.status, seen_result.slot_index,
                     seen_result.evicted_live, seen_result.expired_count);
        end else begin
          want_result = expected_results.pop_front();
          if (seen_result.status !== want_result.status ||
              seen_result.slot_index !== want_result.slot_index ||
              seen_result.evicted_live !== want_result.evicted_live ||
              seen_result.expired_count !== want_result.expired_count) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("[%0t] result mismatch: status %0d/%0d slot %0d/%0d evicted %0d/%0d count %0d/%0d (expected/actual)",
                       $realtime, want_result.status, seen_result.status,
                       want_result.slot_index, seen_result.slot_index,
                       want_result.evicted_live, seen_result.evicted_live,
                       want_result.expired_count, seen_result.expired_count);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        seen_req.mode              = s_tuser[2:0];
        seen_req.token_well_formed = s_tuser[3];
        seen_req.token_digest      = s_tdata[63:0];
        seen_req.now_us            = s_tdata[111:64];
        expected_results.push_back(apply_request(seen_req));
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_request(input logic [MODE_BITS-1:0] mode,
                               input logic [TOKEN_BITS-1:0] digest,
                               input logic well_formed,
                               input logic [TIME_BITS-1:0] now);
    stt_item_t req;
    req.mode              = mode;
    req.token_digest      = digest;
    req.token_well_formed = well_formed;
    req.now_us            = now;
    pending_requests.push_back(req);
  endtask

  // Waits until every request is answered and the block has gone quiet.
  task automatic settle();
    while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both limits back to back; valid stays high between the two.
  task automatic write_limits(input logic [CFG_DATA_BITS-1:0] idle_value,
                              input logic [CFG_DATA_BITS-1:0] life_value);
    cfg_index <= CFG_IDLE_LIMIT;
    cfg_data  <= idle_value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    idle_minutes = idle_value[IDLE_CFG_BITS-1:0];
    cfg_index <= CFG_LIFETIME_LIMIT;
    cfg_data  <= life_value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    life_hours = life_value[LIFE_CFG_BITS-1:0];
    cfg_valid <= 1'b0;
  endtask

  // One phase: new limits and handshake pressure, then a stream of random
  // requests fed a few at a time so that aimed deadlines track the table.
  task automatic run_phase(input logic [CFG_DATA_BITS-1:0] idle_value,
                           input logic [CFG_DATA_BITS-1:0] life_value,
                           input int unsigned send_pct,
                           input int unsigned stall_pct,
                           input bit hold);
    int n;
    settle();
    write_limits(idle_value, life_value);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    if (hold) hold_requests++;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      while (pending_requests.size() >= 4) @(posedge clk);
      pending_requests.push_back(next_request());
    end
  endtask

  initial begin : stimulus
    logic [TIME_BITS-1:0] t0;
    logic [TIME_BITS-1:0] idle0;
    logic [TIME_BITS-1:0] life0;
    int                   k;
    for (k = 0; k < SLOTS; k++) begin
      tbl_valid[k]     = 1'b0;
      tbl_digest[k]    = '0;
      tbl_created[k]   = '0;
      tbl_last_seen[k] = '0;
    end
    digest_pool[0] = '0;
    digest_pool[1] = '1;
    for (k = 2; k < POOL_SIZE; k++) digest_pool[k] = rand64();
    clock_us = TIME_BITS'(rand64());

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset limits.
    t0    = 48'h0000_1000_0000;
    idle0 = 48'd900_000_000;
    life0 = 48'd86_400_000_000;
    queue_request(MODE_VALIDATE, digest_pool[2], 1'b1, t0);
    queue_request(MODE_CREATE, digest_pool[2], 1'b1, t0);
    queue_request(MODE_CREATE, digest_pool[3], 1'b0, t0);
    // Exactly at the idle limit still passes; one past it expires.
    queue_request(MODE_VALIDATE, digest_pool[2], 1'b1, t0 + idle0);
    queue_request(MODE_VALIDATE, digest_pool[2], 1'b1, t0 + 2 * idle0 + 1);
    // Fill the table, refresh slot 0, then force an eviction of slot 1.
    queue_request(MODE_CREATE, digest_pool[1], 1'b1, t0 + 3 * idle0);
    queue_request(MODE_CREATE, digest_pool[0], 1'b1, t0 + 3 * idle0 + 1);
    for (k = 2; k < SLOTS; k++)
      queue_request(MODE_CREATE, digest_pool[k + 1], 1'b1, t0 + 3 * idle0 + k);
    queue_request(MODE_VALIDATE, digest_pool[1], 1'b1, t0 + 3 * idle0 + 10);
    queue_request(MODE_CREATE, digest_pool[9], 1'b1, t0 + 3 * idle0 + 11);
    // Destroy hit, destroy miss and a malformed destroy.
    queue_request(MODE_DESTROY, digest_pool[3], 1'b1, t0 + 3 * idle0 + 12);
    queue_request(MODE_DESTROY, digest_pool[3], 1'b1, t0 + 3 * idle0 + 13);
    queue_request(MODE_DESTROY, digest_pool[4], 1'b0, t0 + 3 * idle0 + 14);
    // Both limits overrun: the lifetime status wins.
    queue_request(MODE_VALIDATE, digest_pool[4], 1'b1, t0 + 3 * idle0 + life0 + 100);
    queue_request(MODE_CLEANUP, digest_pool[5], 1'b0, '1);
    queue_request(MODE_BITS'(5), '1, 1'b1, '1);
    queue_request(MODE_BITS'(6), '0, 1'b0, '0);
    queue_request(MODE_BITS'(7), digest_pool[6], 1'b1, t0);
    // A time difference that wraps past zero.
    queue_request(MODE_CREATE, digest_pool[10], 1'b1, 48'hFFFF_FFFF_FFF0);
    queue_request(MODE_VALIDATE, digest_pool[10], 1'b1, 48'h0000_0000_0010);
    queue_request(MODE_DESTROY_ALL, digest_pool[10], 1'b0, 48'h0000_0000_0020);

    run_phase(14'd15, 14'd24, 0, 0, 1'b0);
    run_phase(14'd1, 14'd1, 84, 0, 1'b0);
    run_phase(14'd1440, 14'd8760, 0, 84, 1'b1);
    run_phase(14'd0, 14'd0, 29, 29, 1'b0);
    // The idle register keeps only its low bits of an oversized write.
    run_phase(14'h3FFF, 14'h3FFF, 0, 0, 1'b0);
    run_phase(14'd5, 14'd2, 84, 0, 1'b0);
    run_phase(14'($urandom_range(1, 1440)), 14'($urandom_range(1, 8760)), 0, 84, 1'b0);
    run_phase(14'd60, 14'd1, 29, 29, 1'b1);

    settle();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
